>>> hw/rtl/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
`default_nettype none
package uer_pkg;

    // field and register widths
    localparam int COUNT_W       = 16;
    localparam int TICK_W        = 8;
    localparam int DIV_W         = 8;
    localparam int DIST_W        = 24;
    localparam int FRACTION_BITS = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DIV_CNT_W     = $clog2(DIST_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 3'd4;

    // configuration reset values
    localparam logic [TICK_W-1:0]  RST_TRIG_LOW  = 8'd4;
    localparam logic [TICK_W-1:0]  RST_TRIG_HIGH = 8'd10;
    localparam logic [COUNT_W-1:0] RST_ECHO_WAIT = 16'd6000;
    localparam logic [COUNT_W-1:0] RST_WIDTH_LIM = 16'd23200;
    localparam logic [DIV_W-1:0]   RST_DIVISOR   = 8'd58;

    // measurement status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_STUCK  = 2'd1;
    localparam logic [1:0] ST_NOECHO = 2'd2;
    localparam logic [1:0] ST_WIDTH  = 2'd3;

    // ranging phase
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_LOW     = 5'b00010,
        PH_HIGH    = 5'b00100,
        PH_WAIT    = 5'b01000,
        PH_MEASURE = 5'b10000
    } t_phase;

    // input word: one tick
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } t_in;

    // output word: one result per tick
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic [DIST_W-1:0] distance_q8;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
    } t_stat;

endpackage
`default_nettype wire

>>> hw/rtl/uer_ctrl.sv
// handshake and sequencing controller of the echo ranger
`default_nettype none
module uer_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire uer_pkg::t_stat i_stat,
    output uer_pkg::t_cmd      o_cmd
);
    import uer_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_DIV  = 2'b10
    } t_cstate;

    t_cstate r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    logic    accept;
    logic    load_out;

    // output register can take a word this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == C_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    // sequencing
    always_comb begin
        n_state      = r_state;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (accept) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.need_div) begin
                        n_state = C_DIV;
                    end
                end
            end
            C_DIV: begin
                if (!i_stat.div_busy && out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    assign load_out = (o_cmd.step && !i_stat.need_div) || o_cmd.finish;

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hw/rtl/uer_dp.sv
// ranging datapath: registers, phase counter, divider and output word
`default_nettype none
module uer_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire uer_pkg::t_in                i_in_word,
    input  wire uer_pkg::t_cmd               i_cmd,
    output uer_pkg::t_stat                   o_stat,
    output uer_pkg::t_out                    o_out_word
);
    import uer_pkg::*;

    // configuration registers
    logic [TICK_W-1:0]  r_trig_low;
    logic [TICK_W-1:0]  r_trig_high;
    logic [COUNT_W-1:0] r_echo_wait;
    logic [COUNT_W-1:0] r_width_lim;
    logic [DIV_W-1:0]   r_divisor;

    // ranging state
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [DIST_W-1:0]  r_dist;
    logic [1:0]         r_status, n_status;
    logic               trig;
    logic               done;
    logic [COUNT_W-1:0] count_inc;

    // divider
    logic [DIST_W-1:0]    r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_W:0]       rem_sh;
    logic                 q_bit;
    logic [DIST_W-1:0]    dividend;

    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= RST_TRIG_LOW;
            r_trig_high <= RST_TRIG_HIGH;
            r_echo_wait <= RST_ECHO_WAIT;
            r_width_lim <= RST_WIDTH_LIM;
            r_divisor   <= RST_DIVISOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIG_LOW:  r_trig_low  <= i_cfg_data[TICK_W-1:0];
                CFG_TRIG_HIGH: r_trig_high <= i_cfg_data[TICK_W-1:0];
                CFG_ECHO_WAIT: r_echo_wait <= i_cfg_data[COUNT_W-1:0];
                CFG_WIDTH_LIM: r_width_lim <= i_cfg_data[COUNT_W-1:0];
                CFG_DIVISOR:   r_divisor   <= i_cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign count_inc = r_count + 1'b1;

    // one tick of the ranging sequence
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_status = r_status;
        trig     = 1'b0;
        done     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_in_word.start_req) begin
                    if (r_trig_low == '0) begin
                        n_phase = PH_HIGH;
                        trig    = 1'b1;
                    end else begin
                        n_phase = PH_LOW;
                    end
                    n_count = COUNT_W'(1);
                end
            end
            PH_LOW: begin
                if (r_count >= COUNT_W'(r_trig_low)) begin
                    n_phase = PH_HIGH;
                    n_count = COUNT_W'(1);
                    trig    = 1'b1;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_HIGH: begin
                if (r_count >= COUNT_W'(r_trig_high)) begin
                    if (i_in_word.echo_level) begin
                        n_status = ST_STUCK;
                        done     = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                    trig    = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_in_word.echo_level) begin
                    // rise tick counts as width one
                    if (r_width_lim <= COUNT_W'(1)) begin
                        n_status = ST_WIDTH;
                        done     = 1'b1;
                        n_phase  = PH_IDLE;
                        n_count  = '0;
                    end else begin
                        n_phase = PH_MEASURE;
                        n_count = COUNT_W'(1);
                    end
                end else begin
                    n_count = count_inc;
                    if (count_inc >= r_echo_wait) begin
                        n_status = ST_NOECHO;
                        done     = 1'b1;
                        n_phase  = PH_IDLE;
                        n_count  = '0;
                    end
                end
            end
            PH_MEASURE: begin
                if (i_in_word.echo_level) begin
                    n_count = count_inc;
                    if (count_inc >= r_width_lim) begin
                        n_status = ST_WIDTH;
                        done     = 1'b1;
                        n_phase  = PH_IDLE;
                        n_count  = '0;
                    end
                end else begin
                    // distance follows from the divider
                    n_status = ST_OK;
                    done     = 1'b1;
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    assign o_stat.need_div = (r_phase == PH_MEASURE) && !i_in_word.echo_level;
    assign o_stat.div_busy = (r_div_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_status <= ST_OK;
            r_dist   <= '0;
        end else begin
            if (i_cmd.step) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_status <= n_status;
            end
            if (i_cmd.finish) begin
                r_dist <= r_quo;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign divisor  = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    assign dividend = DIST_W'({r_count, FRACTION_BITS'(0)});
    assign rem_sh   = {r_rem, r_quo[DIST_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.step && o_stat.need_div) begin
            r_div_cnt <= DIV_CNT_W'(DIST_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && o_stat.need_div) begin
            r_quo <= dividend;
            r_rem <= '0;
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[DIST_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= DIV_W'(rem_sh - {1'b0, divisor});
            end else begin
                r_rem <= rem_sh[DIV_W-1:0];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.trigger_level <= 1'b0;
            r_out.busy_res      <= 1'b0;
            r_out.done_res      <= 1'b1;
            r_out.status        <= ST_OK;
            r_out.distance_q8   <= r_quo;
        end else if (i_cmd.step) begin
            r_out.trigger_level <= trig;
            r_out.busy_res      <= (n_phase != PH_IDLE);
            r_out.done_res      <= done;
            r_out.status        <= n_status;
            r_out.distance_q8   <= r_dist;
        end
    end

    assign o_out_word = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/ultrasonic_echo_ranger_core.sv
// top level of the ultrasonic echo ranger
// Ultrasonic echo ranging controller, one input word per microsecond tick.
// Input channel: i_in_valid / o_in_stall with i_in_word (start request and
// sampled echo level). Output channel: o_out_valid / i_out_stall with
// o_out_word (trigger level, busy, done, status, last distance in Q8 cm).
// Every input word gives exactly one output word.
// A plain word is registered and offered the cycle after acceptance; the
// next word may be taken in that same cycle if the output is free, so one
// word per cycle is sustained.
// The tick that ends a good measurement (echo falling) runs a restoring
// divider of the width by the round-trip divisor, one quotient bit per
// cycle: that word is registered once the divider is done and the output
// is free, and the input stalls meanwhile.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data;
// unknown indexes are ignored. Write only while the block is idle.
// Reset (synchronous, active low) restores register defaults, idles the
// sequence and clears status and distance. While the receiver stalls the
// output word holds and the input stalls once the output register is full.
`default_nettype none
module ultrasonic_echo_ranger_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire uer_pkg::t_in                   i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output uer_pkg::t_out                       o_out_word
);
    import uer_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing and handshakes
    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // ranging datapath
    uer_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire

>>> bench/ultrasonic_echo_ranger_core_tb.sv
// self-checking testbench of the ultrasonic echo ranger core
`default_nettype none
module ultrasonic_echo_ranger_core_tb;
    import uer_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {
        MEAS_OK,
        MEAS_STUCK,
        MEAS_NOECHO,
        MEAS_WIDE
    } t_meas_kind;

    // idle and stall rates of the four traffic modes, percent
    int send_idle_tbl [4] = '{0, 53, 0, 36};
    int recv_stall_tbl[4] = '{0, 0, 53, 36};

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    t_in                   in_word    = '0;
    logic                  out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_word;

    ultrasonic_echo_ranger_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word)
    );

    // stimulus and prediction stores
    t_in  tick_q[$];
    t_out predicted_q[$];
    int   pushed_cnt  = 0;
    int   taken_cnt   = 0;
    int   checked_cnt = 0;
    int   error_cnt   = 0;
    int   phase_cnt   = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_req  = 0;
    int   hold_left = 0;
    bit   in_taken  = 1'b0;
    int   n_ok = 0, n_stuck = 0, n_noecho = 0, n_wide = 0;

    // predictor copy of registers and sequence state
    logic [TICK_W-1:0]  cf_low   = RST_TRIG_LOW;
    logic [TICK_W-1:0]  cf_high  = RST_TRIG_HIGH;
    logic [COUNT_W-1:0] cf_wait  = RST_ECHO_WAIT;
    logic [COUNT_W-1:0] cf_width = RST_WIDTH_LIM;
    logic [DIV_W-1:0]   cf_div   = RST_DIVISOR;
    t_phase             rg_phase  = PH_IDLE;
    logic [COUNT_W-1:0] rg_count  = '0;
    logic [DIST_W-1:0]  rg_dist   = '0;
    logic [1:0]         rg_status = ST_OK;

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // one predicted tick of the ranging sequence
    function automatic t_out range_tick(input t_in w);
        t_out              r;
        logic              trig;
        logic              done;
        logic [DIST_W-1:0] scaled;
        logic [DIV_W-1:0]  d;
        trig = 1'b0;
        done = 1'b0;
        case (rg_phase)
            PH_IDLE: begin
                if (w.start_req) begin
                    if (cf_low == 0) begin
                        rg_phase = PH_HIGH;
                        trig = 1'b1;
                    end else begin
                        rg_phase = PH_LOW;
                    end
                    rg_count = COUNT_W'(1);
                end
            end
            PH_LOW: begin
                if (rg_count >= cf_low) begin
                    rg_phase = PH_HIGH;
                    rg_count = COUNT_W'(1);
                    trig = 1'b1;
                end else begin
                    rg_count = rg_count + 1'b1;
                end
            end
            PH_HIGH: begin
                if (rg_count >= cf_high) begin
                    if (w.echo_level) begin
                        rg_status = ST_STUCK;
                        done = 1'b1;
                        rg_phase = PH_IDLE;
                    end else begin
                        rg_phase = PH_WAIT;
                    end
                    rg_count = '0;
                end else begin
                    rg_count = rg_count + 1'b1;
                    trig = 1'b1;
                end
            end
            PH_WAIT: begin
                if (w.echo_level) begin
                    rg_count = COUNT_W'(1);
                    if (rg_count >= cf_width) begin
                        rg_status = ST_WIDTH;
                        done = 1'b1;
                        rg_phase = PH_IDLE;
                        rg_count = '0;
                    end else begin
                        rg_phase = PH_MEASURE;
                    end
                end else begin
                    rg_count = rg_count + 1'b1;
                    if (rg_count >= cf_wait) begin
                        rg_status = ST_NOECHO;
                        done = 1'b1;
                        rg_phase = PH_IDLE;
                        rg_count = '0;
                    end
                end
            end
            PH_MEASURE: begin
                if (w.echo_level) begin
                    rg_count = rg_count + 1'b1;
                    if (rg_count >= cf_width) begin
                        rg_status = ST_WIDTH;
                        done = 1'b1;
                        rg_phase = PH_IDLE;
                        rg_count = '0;
                    end
                end else begin
                    // echo fell: width to fixed-point distance
                    d = (cf_div == 0) ? DIV_W'(1) : cf_div;
                    scaled = DIST_W'(rg_count);
                    scaled = scaled << FRACTION_BITS;
                    rg_dist = scaled / DIST_W'(d);
                    rg_status = ST_OK;
                    done = 1'b1;
                    rg_phase = PH_IDLE;
                    rg_count = '0;
                end
            end
            default: begin
                rg_phase = PH_IDLE;
                rg_count = '0;
            end
        endcase
        if (done) begin
            case (rg_status)
                ST_OK:     n_ok++;
                ST_STUCK:  n_stuck++;
                ST_NOECHO: n_noecho++;
                default:   n_wide++;
            endcase
        end
        r.trigger_level = trig;
        r.busy_res      = (rg_phase != PH_IDLE);
        r.done_res      = done;
        r.status        = rg_status;
        r.distance_q8   = rg_dist;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_cnt++;
        if (error_cnt <= 30)
            $display("mismatch at %0t, word %0d: %s", $realtime, checked_cnt, msg);
    endtask

    // input side: predict each accepted word; output side: compare
    always @(posedge i_clk) begin
        t_out want;
        if (in_valid && !o_in_stall) begin
            predicted_q.push_back(range_tick(in_word));
            in_taken = 1'b1;
            taken_cnt++;
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (predicted_q.size() == 0) begin
                report_mismatch("output word with nothing predicted");
            end else begin
                want = predicted_q.pop_front();
                if (o_out_word.trigger_level !== want.trigger_level)
                    report_mismatch($sformatf("trigger got %b want %b",
                        o_out_word.trigger_level, want.trigger_level));
                if (o_out_word.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy got %b want %b",
                        o_out_word.busy_res, want.busy_res));
                if (o_out_word.done_res !== want.done_res)
                    report_mismatch($sformatf("done got %b want %b",
                        o_out_word.done_res, want.done_res));
                if (o_out_word.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        o_out_word.status, want.status));
                if (o_out_word.distance_q8 !== want.distance_q8)
                    report_mismatch($sformatf("distance got %0d want %0d",
                        o_out_word.distance_q8, want.distance_q8));
            end
            checked_cnt++;
        end
    end

    // driver: offer queued ticks, with random gaps
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= tick_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_tick(input logic start, input logic echo);
        t_in w;
        w.start_req  = start;
        w.echo_level = echo;
        tick_q.push_back(w);
        pushed_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TRIG_LOW:  cf_low   = data[TICK_W-1:0];
            CFG_TRIG_HIGH: cf_high  = data[TICK_W-1:0];
            CFG_ECHO_WAIT: cf_wait  = data;
            CFG_WIDTH_LIM: cf_width = data;
            CFG_DIVISOR:   cf_div   = data[DIV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int low, input int high, input int wait_lim,
                             input int width_lim, input int div);
        write_reg(CFG_TRIG_LOW,  CFG_DATA_W'(low));
        write_reg(CFG_TRIG_HIGH, CFG_DATA_W'(high));
        write_reg(CFG_ECHO_WAIT, CFG_DATA_W'(wait_lim));
        write_reg(CFG_WIDTH_LIM, CFG_DATA_W'(width_lim));
        write_reg(CFG_DIVISOR,   CFG_DATA_W'(div));
    endtask

    // small random setting, junk in the unused upper bits of byte registers
    task automatic write_random_config();
        int r_wait, r_width, r_div, v_wait, v_width, v_div;
        r_wait  = $urandom_range(9);
        r_width = $urandom_range(9);
        r_div   = $urandom_range(9);
        v_wait  = (r_wait == 0) ? 0 : (r_wait == 1) ? 65535 : $urandom_range(30, 1);
        v_width = (r_width == 0) ? 0 : (r_width == 1) ? 1 :
                  (r_width == 2) ? 65535 : $urandom_range(40, 2);
        v_div   = (r_div == 0) ? 0 : (r_div == 1) ? 1 :
                  (r_div == 2) ? 255 : $urandom_range(255, 1);
        write_reg(CFG_TRIG_LOW,  {8'($urandom), 8'($urandom_range(6))});
        write_reg(CFG_TRIG_HIGH, {8'($urandom), 8'($urandom_range(6))});
        write_reg(CFG_ECHO_WAIT, CFG_DATA_W'(v_wait));
        write_reg(CFG_WIDTH_LIM, CFG_DATA_W'(v_width));
        write_reg(CFG_DIVISOR,   {8'($urandom), 8'(v_div)});
        // unknown index must change nothing
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_DIVISOR + 1)),
                  CFG_DATA_W'($urandom));
    endtask

    // one ranging sequence shaped for the current setting
    // wait_n / width below zero pick random values
    task automatic add_ranging(input t_meas_kind kind, input int wait_n, input int width);
        int pre;
        int lim;
        pre = int'(cf_low) + ((cf_high == 0) ? 1 : int'(cf_high)) - 1;
        if (kind == MEAS_NOECHO && cf_wait > 200) kind = MEAS_OK;
        if (kind == MEAS_WIDE && cf_width > 200) kind = MEAS_OK;
        if (kind == MEAS_OK && cf_width <= 1) kind = MEAS_WIDE;
        push_tick(1'b1, 1'b0);
        // echo is not looked at before the trigger pulse ends
        repeat (pre) push_tick(1'b0, $urandom_range(7) == 0);
        push_tick(1'b0, kind == MEAS_STUCK);
        if (kind == MEAS_STUCK) return;
        if (kind == MEAS_NOECHO) begin
            repeat ((cf_wait == 0) ? 1 : int'(cf_wait)) push_tick(1'b0, 1'b0);
            return;
        end
        if (wait_n < 0) begin
            lim = int'(cf_wait) - 1;
            wait_n = (cf_wait <= 1) ? 0 : $urandom_range((lim < 20) ? lim : 20);
        end
        repeat (wait_n) push_tick(1'b0, 1'b0);
        if (kind == MEAS_WIDE) begin
            repeat ((cf_width == 0) ? 1 : int'(cf_width)) push_tick(1'b0, 1'b1);
            push_tick(1'b0, 1'b0);
            return;
        end
        if (width <= 0) begin
            lim = int'(cf_width) - 1;
            width = $urandom_range((lim < 60) ? lim : 60, 1);
        end
        repeat (width) push_tick(1'b0, 1'b1);
        // the done tick, sometimes with a start that must be ignored
        push_tick(1'($urandom_range(1)), 1'b0);
    endtask

    function automatic t_meas_kind pick_kind();
        int r;
        r = $urandom_range(9);
        if (r < 7) return MEAS_OK;
        if (r == 7) return MEAS_STUCK;
        if (r == 8) return MEAS_NOECHO;
        return MEAS_WIDE;
    endfunction

    // mostly well-formed sequences, some random ticks
    task automatic add_traffic(input int budget);
        int base;
        base = pushed_cnt;
        while (pushed_cnt - base < budget) begin
            if ($urandom_range(9) < 8)
                add_ranging(pick_kind(), -1, -1);
            else
                repeat ($urandom_range(6, 1))
                    push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        // leave a sequence running across the next register writes
        push_tick(1'b1, 1'b0);
    endtask

    task automatic set_mode(input int m);
        send_idle_pct  = send_idle_tbl[m];
        recv_stall_pct = recv_stall_tbl[m];
        phase_cnt++;
    endtask

    // wait until every tick is accepted and answered, then let the block settle
    task automatic drain();
        while (taken_cnt != pushed_cnt || predicted_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: one good measurement at reset settings
        set_mode(0);
        push_tick(1'b0, 1'b1);
        add_ranging(MEAS_OK, 1, 4);
        drain();

        // directed: zero low and high ticks, zero wait, width limit one, zero divisor
        write_all(0, 0, 0, 1, 0);
        add_ranging(MEAS_STUCK, -1, -1);
        add_ranging(MEAS_NOECHO, -1, -1);
        add_ranging(MEAS_WIDE, -1, -1);
        drain();

        // widest trigger and limits
        set_mode(1);
        write_all(255, 255, 65535, 65535, 255);
        add_ranging(MEAS_OK, 30, 100);
        drain();

        // narrowest legal limits, divisor one
        set_mode(2);
        write_all(0, 1, 1, 2, 1);
        add_traffic(60);
        drain();

        // random settings across all traffic modes
        for (int p = 0; p < 8; p++) begin
            write_random_config();
            set_mode(p % 4);
            if (p == 1) hold_req = HOLD_CYCLES;
            add_traffic(65);
            drain();
        end

        if (predicted_q.size() != 0)
            report_mismatch("predicted words left over");
        $display("ranger run: %0d ticks driven, %0d words checked, %0d setting phases",
                 pushed_cnt, checked_cnt, phase_cnt);
        $display("measurements ended: ok %0d, stuck high %0d, no echo %0d, too wide %0d",
                 n_ok, n_stuck, n_noecho, n_wide);
        if (error_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("run timed out with %0d words outstanding", predicted_q.size());
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/uer_pkg.sv
hw/rtl/uer_ctrl.sv
hw/rtl/uer_dp.sv
hw/rtl/ultrasonic_echo_ranger_core.sv
bench/ultrasonic_echo_ranger_core_tb.sv
